@@ rtl/core/taps_pkg.sv @@
package taps_pkg;

  // Default build-time configuration
  localparam int TAPS_COORD_BITS = 24;
  localparam int TAPS_EXP_DEPTH  = 256;
  localparam int TAPS_ALPHA_FRAC = 16;

  // Fixed field and register widths
  localparam int TIME_W      = 32;
  localparam int TAU_W       = 16;
  localparam int ORIGIN_W    = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int F_W         = 32;  // filter state width
  localparam int ROM_W       = 31;  // Q30 exponential entries, 1.0 included
  localparam int Q_ONE_BITS  = 30;
  localparam int FRAC_IDX_W  = 16;  // fraction bits of the table position

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_CONSTANT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_ONLY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_COL    = 2'd2;

  // Register reset values
  localparam logic [TAU_W-1:0]           TAU_RESET    = 16'd100;
  localparam logic signed [ORIGIN_W-1:0] ORIGIN_RESET = 24'sd2048;

  typedef logic [TIME_W-1:0] stamp_t;
  typedef logic [ROM_W-1:0]  rom_word_t;

endpackage

@@ rtl/core/taps_rom.sv @@
module taps_rom #(
  parameter  int DEPTH = taps_pkg::TAPS_EXP_DEPTH,
  localparam int AW    = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic [AW-1:0]       addr,
  output taps_pkg::rom_word_t data_r
);
  import taps_pkg::*;

  localparam int N = DEPTH + 1;
  localparam logic [63:0] XQ = (64'd16 << Q_ONE_BITS) / DEPTH;

  typedef rom_word_t rom_arr_t [N];

  // exp(-16/DEPTH) by truncated Taylor series, then repeated rounded products
  function automatic rom_arr_t build_rom();
    rom_arr_t          t;
    logic [63:0]       term;
    logic [63:0]       r;
    logic [63:0]       prod;
    logic signed [63:0] sum;
    term = 64'd1 << Q_ONE_BITS;
    sum  = signed'(64'd1 << Q_ONE_BITS);
    for (int n = 1; n <= 16; n++) begin
      term = ((term * XQ) >> Q_ONE_BITS) / 64'(n);
      if (n[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    r = unsigned'(sum);
    t[0] = ROM_W'(64'd1 << Q_ONE_BITS);
    for (int k = 1; k < N; k++) begin
      prod = 64'(t[k-1]) * r + (64'd1 << (Q_ONE_BITS - 1));
      t[k] = ROM_W'(prod >> Q_ONE_BITS);
    end
    return t;
  endfunction

  localparam rom_arr_t ROM = build_rom();

  always_ff @(posedge clk) begin
    data_r <= ROM[addr];
  end

endmodule

@@ rtl/core/taps_mul.sv @@
module taps_mul #(
  parameter int AW = taps_pkg::F_W,
  parameter int BW = taps_pkg::FRAC_IDX_W
) (
  input  logic             clk,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p_r
);

  // Registered unsigned product, one result per cycle
  always_ff @(posedge clk) begin
    p_r <= (AW+BW)'(a) * (AW+BW)'(b);
  end

endmodule

@@ rtl/core/taps_div.sv @@
module taps_div #(
  parameter int NW = 57,
  parameter int QW = 24,
  parameter int DW = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quo
);
  localparam int CW = $clog2(QW + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW:0]   trial;
  logic          qbit;

  // Restoring division, one quotient bit per cycle. The caller guarantees
  // that the quotient fits in QW bits, so the top of num starts below den.
  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    trial   = {rem_r, q_r[QW-1]};
    qbit    = 1'b0;
    if (start) begin
      rem_nxt = num[QW +: DW];
      q_nxt   = num[QW-1:0];
      den_nxt = den;
      cnt_nxt = CW'(QW);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, den_r}) begin
        qbit    = 1'b1;
        rem_nxt = DW'(trial - {1'b0, den_r});
      end else begin
        rem_nxt = DW'(trial);
      end
      q_nxt   = {q_r[QW-2:0], qbit};
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = (cnt_r == '0);
  assign quo  = q_r;

endmodule

@@ rtl/core/time_adaptive_pointer_smoother_top.sv @@
// Time-adaptive pointer smoother: an exponential moving average whose weight
// follows the time since the last update. Each input transfer is one timer
// tick; each tick gives exactly one result transfer. A tick without a pointer
// position reports stopped (all zero fields) and leaves the state alone. With
// a position, dt = tick_time - last update time (mod 2^32) sets the weight
// alpha = 1 - exp(-dt/tau), read from an exponential ROM with linear
// interpolation, and X/Y are blended toward the new sample. Forward-only mode
// loads the raw sample when pointer_x is at or right of the forward-only
// origin. One item is worked on at a time. A smoothed tick with dt below
// 16*tau runs the table position through a restoring divider that yields
// log2(depth)+16 bits, one per cycle, then two ROM reads and three passes
// through one shared multiplier (interpolation, X blend, Y blend): the result
// is presented and the input is ready again from the same cycle. With dt of
// 16*tau or more the divider is skipped (alpha = 1). Stopped and pass-through
// ticks go straight to the output step. The input is taken again while a
// result waits in the output register; a finished result waits only for that
// register to empty. Configuration writes are always taken (cfg_ready is
// tied high).
module time_adaptive_pointer_smoother_top #(
  parameter  int COORD_BITS          = taps_pkg::TAPS_COORD_BITS,
  parameter  int EXP_TABLE_DEPTH     = taps_pkg::TAPS_EXP_DEPTH,
  parameter  int ALPHA_FRACTION_BITS = taps_pkg::TAPS_ALPHA_FRAC,
  localparam int IN_DW  = ((taps_pkg::TIME_W + 2 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_DW = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // tick input
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [IN_DW-1:0]                    in_tdata,  // tick_time, pointer_x, pointer_y
  input  logic                                in_tuser,  // position_valid
  // result output
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [OUT_DW-1:0]                   out_tdata, // smoothed_x, smoothed_y
  output logic [1:0]                          out_tuser, // move_valid, smoothing_active
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [taps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [taps_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import taps_pkg::*;

  localparam int FF     = F_W - COORD_BITS;             // filter fraction bits
  localparam int AFB    = ALPHA_FRACTION_BITS;
  localparam int AL_W   = AFB + 1;
  localparam int RA_W   = $clog2(EXP_TABLE_DEPTH + 1);  // ROM address width
  localparam int IW     = $clog2(EXP_TABLE_DEPTH);      // table index width
  localparam int QW     = IW + FRAC_IDX_W;              // table position width
  localparam int DW     = TAU_W + 4;                    // 16*tau
  localparam int NW     = TIME_W + RA_W + FRAC_IDX_W;   // dt*depth*2^16
  localparam int MB_W   = (AL_W > FRAC_IDX_W) ? AL_W : FRAC_IDX_W;
  localparam int PW     = F_W + MB_W;
  localparam int CMP_W  = ((COORD_BITS > ORIGIN_W) ? COORD_BITS : ORIGIN_W) + 1;

  localparam logic [31:0] ONE_Q    = 32'd1 << Q_ONE_BITS;
  localparam logic [31:0] HALF_LSB = 32'd1 << (Q_ONE_BITS - 1 - AFB);
  localparam logic [AL_W-1:0] ALPHA_ONE = AL_W'(1) << AFB;
  localparam logic signed [F_W:0] RND_MASK  = ((F_W+1)'(1) << FF) - (F_W+1)'(1);
  localparam logic signed [F_W:0] RND_ZERO  = '0;

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIV  = 4'd1;  // table position divide
  localparam logic [3:0] ST_RA   = 4'd2;  // read t[i]
  localparam logic [3:0] ST_RB   = 4'd3;  // read t[i+1], hold t[i]
  localparam logic [3:0] ST_RC   = 4'd4;  // interpolation multiply
  localparam logic [3:0] ST_MI   = 4'd5;  // form alpha
  localparam logic [3:0] ST_BX   = 4'd6;  // X blend multiply
  localparam logic [3:0] ST_BY   = 4'd7;  // X update, Y blend multiply
  localparam logic [3:0] ST_FY   = 4'd8;  // Y update
  localparam logic [3:0] ST_OUT  = 4'd9;  // wait for output register

  // truncate a filter value toward zero to a coordinate
  function automatic logic [COORD_BITS-1:0] to_coord(input logic signed [F_W-1:0] f);
    logic signed [F_W:0] biased;
    biased = (F_W+1)'(f) + (f[F_W-1] ? RND_MASK : RND_ZERO);
    return COORD_BITS'(biased >>> FF);
  endfunction

  logic [3:0]                   state_r, state_nxt;
  logic [TAU_W-1:0]             tau_r, tau_nxt;
  logic                         fwd_r, fwd_nxt;
  logic signed [ORIGIN_W-1:0]   origin_r, origin_nxt;
  logic signed [F_W-1:0]        fx_r, fx_nxt, fy_r, fy_nxt;
  stamp_t                       last_r, last_nxt;
  logic                         act_r, act_nxt;
  logic                         mv_r, mv_nxt;
  logic signed [COORD_BITS-1:0] x_r, x_nxt, y_r, y_nxt;
  rom_word_t                    a_r, a_nxt;
  logic [AL_W-1:0]              alpha_r, alpha_nxt;
  logic                         out_tvalid_r, out_tvalid_nxt;
  logic [COORD_BITS-1:0]        out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic                         out_mv_r, out_mv_nxt, out_act_r, out_act_nxt;

  stamp_t                       in_t;
  logic signed [COORD_BITS-1:0] in_x, in_y;
  logic signed [F_W-1:0]        in_xs, in_ys, xs, ys;
  logic                         accept, smooth_in, far;
  stamp_t                       dt;
  logic [TAU_W-1:0]             tau_eff;
  logic [DW-1:0]                den;
  logic [NW-1:0]                num;
  logic                         div_start, div_done;
  logic [QW-1:0]                quo;
  logic [RA_W-1:0]              rom_addr;
  rom_word_t                    rom_data;
  logic [F_W-1:0]               mul_a;
  logic [MB_W-1:0]              mul_b;
  logic [PW-1:0]                prod_r;
  logic signed [F_W:0]          dx, dy;
  logic [F_W-1:0]               mag_x, mag_y, delta;
  rom_word_t                    e_val;
  logic [31:0]                  alpha_full;

  // unpack the input transfer
  assign in_t = in_tdata[TIME_W-1:0];
  assign in_x = in_tdata[TIME_W +: COORD_BITS];
  assign in_y = in_tdata[TIME_W + COORD_BITS +: COORD_BITS];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign in_xs = F_W'(in_x) <<< FF;
  assign in_ys = F_W'(in_y) <<< FF;
  assign xs    = F_W'(x_r) <<< FF;
  assign ys    = F_W'(y_r) <<< FF;

  // forward test and time step
  assign smooth_in = (CMP_W'(in_x) < CMP_W'(origin_r)) || !fwd_r;
  assign dt        = in_t - last_r;
  assign tau_eff   = (tau_r == '0) ? TAU_W'(1) : tau_r;
  assign den       = {tau_eff, 4'b0000};
  // past the end of the table exactly when dt >= 16*tau
  assign far       = (dt >= TIME_W'(den));
  assign num       = (NW'(dt) * NW'(EXP_TABLE_DEPTH)) << FRAC_IDX_W;
  assign div_start = accept && in_tuser && smooth_in && !far;

  taps_div #(.NW(NW), .QW(QW), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  // table index from the integer part, next entry on the second read
  assign rom_addr = RA_W'(quo[QW-1:FRAC_IDX_W]) + RA_W'(state_r == ST_RB);

  taps_rom #(.DEPTH(EXP_TABLE_DEPTH)) u_rom (
    .clk    (clk),
    .addr   (rom_addr),
    .data_r (rom_data)
  );

  // blend distances, sign-magnitude into the multiplier
  assign dx    = (F_W+1)'(xs) - (F_W+1)'(fx_r);
  assign dy    = (F_W+1)'(ys) - (F_W+1)'(fy_r);
  assign mag_x = dx[F_W] ? F_W'(-dx) : F_W'(dx);
  assign mag_y = dy[F_W] ? F_W'(-dy) : F_W'(dy);

  always_comb begin
    case (state_r)
      ST_RC: begin
        mul_a = F_W'(a_r - rom_data);
        mul_b = MB_W'(quo[FRAC_IDX_W-1:0]);
      end
      ST_BX: begin
        mul_a = mag_x;
        mul_b = MB_W'(alpha_r);
      end
      ST_BY: begin
        mul_a = mag_y;
        mul_b = MB_W'(alpha_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  taps_mul #(.AW(F_W), .BW(MB_W)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  assign delta      = F_W'(prod_r >> AFB);
  assign e_val      = a_r - ROM_W'(prod_r >> FRAC_IDX_W);
  assign alpha_full = ONE_Q - 32'(e_val) + HALF_LSB;

  always_comb begin
    state_nxt      = state_r;
    tau_nxt        = tau_r;
    fwd_nxt        = fwd_r;
    origin_nxt     = origin_r;
    fx_nxt         = fx_r;
    fy_nxt         = fy_r;
    last_nxt       = last_r;
    act_nxt        = act_r;
    mv_nxt         = mv_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    a_nxt          = a_r;
    alpha_nxt      = alpha_r;
    out_tvalid_nxt = out_tvalid_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_mv_nxt     = out_mv_r;
    out_act_nxt    = out_act_r;

    // configuration writes
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TIME_CONSTANT: tau_nxt    = cfg_data[TAU_W-1:0];
        CFG_FORWARD_ONLY:  fwd_nxt    = cfg_data[0];
        CFG_ORIGIN_COL:    origin_nxt = cfg_data[ORIGIN_W-1:0];
        default: ;
      endcase
    end

    // drop the held result once taken
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!in_tuser) begin
            mv_nxt    = 1'b0;
            state_nxt = ST_OUT;
          end else begin
            mv_nxt   = 1'b1;
            x_nxt    = in_x;
            y_nxt    = in_y;
            last_nxt = in_t;
            act_nxt  = smooth_in;
            if (!smooth_in) begin
              fx_nxt    = in_xs;
              fy_nxt    = in_ys;
              state_nxt = ST_OUT;
            end else if (far) begin
              alpha_nxt = ALPHA_ONE;
              state_nxt = ST_BX;
            end else begin
              state_nxt = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_RA;
        end
      end
      ST_RA: state_nxt = ST_RB;
      ST_RB: begin
        a_nxt     = rom_data;
        state_nxt = ST_RC;
      end
      ST_RC: state_nxt = ST_MI;
      ST_MI: begin
        alpha_nxt = alpha_full[Q_ONE_BITS - AFB +: AL_W];
        state_nxt = ST_BX;
      end
      ST_BX: state_nxt = ST_BY;
      ST_BY: begin
        fx_nxt    = dx[F_W] ? fx_r - delta : fx_r + delta;
        state_nxt = ST_FY;
      end
      ST_FY: begin
        fy_nxt    = dy[F_W] ? fy_r - delta : fy_r + delta;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_mv_nxt     = mv_r;
          out_x_nxt      = mv_r ? to_coord(fx_r) : '0;
          out_y_nxt      = mv_r ? to_coord(fy_r) : '0;
          out_act_nxt    = mv_r && act_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tau_r        <= TAU_RESET;
      fwd_r        <= 1'b0;
      origin_r     <= ORIGIN_RESET;
      fx_r         <= '0;
      fy_r         <= '0;
      last_r       <= '0;
      act_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tau_r        <= tau_nxt;
      fwd_r        <= fwd_nxt;
      origin_r     <= origin_nxt;
      fx_r         <= fx_nxt;
      fy_r         <= fy_nxt;
      last_r       <= last_nxt;
      act_r        <= act_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mv_r      <= mv_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    a_r       <= a_nxt;
    alpha_r   <= alpha_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_mv_r  <= out_mv_nxt;
    out_act_r <= out_act_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DW'({out_y_r, out_x_r});
  assign out_tuser  = {out_act_r, out_mv_r};

endmodule

@@ rtl/core/taps_chk.sv @@
module taps_chk #(
  parameter  int COORD_BITS = taps_pkg::TAPS_COORD_BITS,
  localparam int OUT_DW     = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic [1:0]        out_tuser
);

  // one tick in flight: no transfer right after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again while a tick is in flight");

  // a new result only appears after the sequencer was busy
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a tick being processed");

  // stopped results carry all-zero fields
  a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata == '0) && !out_tuser[1])
    else $error("stopped result with nonzero fields");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // reset leaves the block empty and ready
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not empty after reset");

endmodule

bind time_adaptive_pointer_smoother_top taps_chk #(.COORD_BITS(COORD_BITS)) u_taps_chk (.*);

@@ bench/tb_time_adaptive_pointer_smoother_top.sv @@
`timescale 1ns / 1ps

// Bench for the time-adaptive pointer smoother. A driver feeds ticks from a
// queue in random bursts, a receiver stalls on its own pattern, and every
// accepted tick is run through a local model of the filter. Each result
// transfer is checked field by field against the oldest predicted move.
module tb_time_adaptive_pointer_smoother_top;
  import taps_pkg::*;

  localparam int CW        = TAPS_COORD_BITS;
  localparam int DEPTH     = TAPS_EXP_DEPTH;
  localparam int AFB       = TAPS_ALPHA_FRAC;
  localparam int FF        = F_W - CW;  // fraction bits of the filter state
  localparam int IN_W      = ((TIME_W + 2 * CW + 7) / 8) * 8;
  localparam int OUT_W     = ((2 * CW + 7) / 8) * 8;
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam longint unsigned Q30_ONE = 64'd1 << Q_ONE_BITS;
  localparam int SETTLE_CYCLES = 48;    // longer than the divider path latency
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_TICKS   = 135;

  typedef struct packed {
    logic [TIME_W-1:0]   stamp;
    logic                pos_valid;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } tick_t;

  typedef struct packed {
    logic          move_valid;
    logic [CW-1:0] smoothed_x;
    logic [CW-1:0] smoothed_y;
    logic          smoothing_active;
  } move_t;

  logic clk = 1'b0;
  logic rst_n;

  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata = '0;   // tick_time, pointer_x, pointer_y
  logic               in_tuser = 1'b0; // position_valid
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_W-1:0]   out_tdata;       // smoothed_x, smoothed_y
  logic [1:0]         out_tuser;       // move_valid, smoothing_active
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  time_adaptive_pointer_smoother_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Local filter model: register copies, filter state and the exp table.
  // ---------------------------------------------------------------------------
  logic [TAU_W-1:0]           tau_sh;
  logic                       fwd_sh;
  logic signed [ORIGIN_W-1:0] origin_sh;
  longint                     filt_x, filt_y;
  logic [TIME_W-1:0]          last_stamp;
  longint unsigned            exp_q30 [0:DEPTH];

  // exp(-16k/DEPTH) in Q30: Taylor series for the step ratio, then repeated
  // rounded products.
  function automatic void build_exp_table();
    longint unsigned step_q, term, ratio;
    longint sum;
    step_q = (64'd16 << Q_ONE_BITS) / DEPTH;
    term   = Q30_ONE;
    sum    = longint'(Q30_ONE);
    for (int n = 1; n <= 16; n++) begin
      term = ((term * step_q) >> Q_ONE_BITS) / n;
      if (n % 2) sum -= longint'(term);
      else sum += longint'(term);
    end
    ratio = longint'(sum);
    exp_q30[0] = Q30_ONE;
    for (int n = 1; n <= DEPTH; n++)
      exp_q30[n] = (exp_q30[n-1] * ratio + (Q30_ONE >> 1)) >> Q_ONE_BITS;
  endfunction

  // alpha = 1 - exp(-dt/tau) with linear interpolation, AFB fraction bits
  function automatic longint unsigned alpha_for_dt(logic [TIME_W-1:0] dt);
    longint unsigned dt64, tau_eff, pos, idx, frac, e, a, b;
    dt64    = dt;
    tau_eff = (tau_sh == 0) ? 64'd1 : 64'(tau_sh);
    pos     = ((dt64 * DEPTH) << FRAC_IDX_W) / (64'd16 * tau_eff);
    idx     = pos >> FRAC_IDX_W;
    frac    = pos & ((64'd1 << FRAC_IDX_W) - 1);
    e       = 0;
    if (idx < DEPTH) begin
      a = exp_q30[idx];
      b = exp_q30[idx + 1];
      e = a - (((a - b) * frac) >> FRAC_IDX_W);
    end
    return (Q30_ONE - e + (64'd1 << (Q_ONE_BITS - 1 - AFB))) >> (Q_ONE_BITS - AFB);
  endfunction

  // move f toward the new sample by alpha, truncating the step toward zero
  function automatic longint blend_toward(longint f, longint x, longint unsigned alpha);
    longint d;
    longint unsigned mag;
    d = x * (longint'(1) << FF) - f;
    if (d < 0) begin
      mag = -d;
      return f - longint'((mag * alpha) >> AFB);
    end
    mag = d;
    return f + longint'((mag * alpha) >> AFB);
  endfunction

  function automatic logic [CW-1:0] filter_to_coord(longint f);
    longint q;
    if (f < 0) q = -((-f) >> FF);
    else q = f >> FF;
    return q[CW-1:0];
  endfunction

  // Advance the model by one tick and return the move it should produce.
  function automatic move_t smooth_tick(tick_t tk);
    move_t res;
    longint xs, ys;
    longint unsigned alpha;
    res = '0;
    if (!tk.pos_valid) return res;  // stopped: state stays as it is
    xs = tk.px;
    ys = tk.py;
    if (tk.px < origin_sh || !fwd_sh) begin
      alpha  = alpha_for_dt(tk.stamp - last_stamp);
      filt_x = blend_toward(filt_x, xs, alpha);
      filt_y = blend_toward(filt_y, ys, alpha);
      res.smoothing_active = 1'b1;
    end else begin
      // forward-only pass-through: load the raw sample
      filt_x = xs * (longint'(1) << FF);
      filt_y = ys * (longint'(1) << FF);
    end
    last_stamp       = tk.stamp;
    res.move_valid   = 1'b1;
    res.smoothed_x   = filter_to_coord(filt_x);
    res.smoothed_y   = filter_to_coord(filt_y);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer queued ticks in bursts, predict each one as it transfers.
  // ---------------------------------------------------------------------------
  tick_t pending_ticks [$];
  move_t expected_moves [$];
  tick_t cur_tick;
  int    burst_left = 0;
  int    gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      // the offered tick (if any) transferred at this edge
      if (in_tvalid) expected_moves.push_back(smooth_tick(cur_tick));
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
        cur_tick = pending_ticks.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {cur_tick.py, cur_tick.px, cur_tick.stamp};
        in_tuser  <= cur_tick.pos_valid;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // long bursts now and then give stretches with no idling at all
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver and checker. Stall modes: always ready, coin flip, mostly
  // stalled. One long hold-off lets the block back up into its input.
  // ---------------------------------------------------------------------------
  int    field_mismatches = 0;
  int    results_seen = 0;
  int    stall_mode = 0;
  int    mode_left = 0;
  int    hold_left = 0;
  bit    hold_done = 1'b0;
  move_t got_move;
  move_t want_move;

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      field_mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        got_move = {out_tuser[0], out_tdata[CW-1:0], out_tdata[2*CW-1:CW], out_tuser[1]};
        if (expected_moves.size() == 0) begin
          $error("result transfer with no tick outstanding");
          field_mismatches++;
        end else begin
          want_move = expected_moves.pop_front();
          check_field("move_valid", want_move.move_valid, got_move.move_valid);
          check_field("smoothed_x", want_move.smoothed_x, got_move.smoothed_x);
          check_field("smoothed_y", want_move.smoothed_y, got_move.smoothed_y);
          check_field("smoothing_active", want_move.smoothing_active,
                      got_move.smoothing_active);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && results_seen >= 400 && pending_ticks.size() > 16) begin
        // hold off long enough for the input side to back up
        hold_done = 1'b1;
        hold_left = 300;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left  = $urandom_range(16, 128);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 1) != 0);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_tick(logic [TIME_W-1:0] stamp, logic pv,
                                     logic [CW-1:0] x, logic [CW-1:0] y);
    tick_t tk;
    tk.stamp     = stamp;
    tk.pos_valid = pv;
    tk.px        = x;
    tk.py        = y;
    pending_ticks.push_back(tk);
  endfunction

  // mostly small coordinates, some near a center, some extremes, some full range
  function automatic logic [CW-1:0] pick_coord(int center);
    int v;
    case ($urandom_range(0, 9))
      0: return CW'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0:       v = COORD_MAX;
          1:       v = COORD_MIN;
          2:       v = 0;
          default: v = -1;
        endcase
      end
      2, 3, 4: v = center + int'($urandom_range(0, 128)) - 64;
      default: v = int'($urandom_range(0, 8191)) - 4096;
    endcase
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v[CW-1:0];
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TIME_CONSTANT: tau_sh    = val[TAU_W-1:0];
      CFG_FORWARD_ONLY:  fwd_sh    = val[0];
      CFG_ORIGIN_COL:    origin_sh = val[ORIGIN_W-1:0];
      default: ;
    endcase
  endtask

  // block is idle once every tick has transferred and every move has arrived
  task automatic wait_idle();
    while (pending_ticks.size() != 0 || in_tvalid || expected_moves.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [TIME_W-1:0]   gen_time;
    logic [TIME_W-1:0]   dt;
    logic [TAU_W-1:0]    tau;
    logic signed [CW-1:0] org;
    int unsigned         span;
    int                  sel;

    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TIME_CONSTANT;
    cfg_data  = '0;
    build_exp_table();
    tau_sh     = TAU_RESET;
    fwd_sh     = 1'b0;
    origin_sh  = ORIGIN_RESET;
    filt_x     = 0;
    filt_y     = 0;
    last_stamp = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset settings (tau 100): first tick measured from time 0,
    // zero dt, stopped ticks, the table end at 16*tau, wraparound of time.
    queue_tick(32'd50, 1'b1, COORD_MAX, COORD_MIN);
    queue_tick(32'd50, 1'b1, COORD_MIN, COORD_MAX);
    queue_tick(32'd60, 1'b0, 24'd123, -24'sd5);
    queue_tick(32'd1650, 1'b1, '0, '0);
    queue_tick(32'd3249, 1'b1, '1, '1);
    queue_tick(32'hFFFF_FFF0, 1'b1, 24'd1000, -24'sd1000);
    queue_tick(32'h0000_0010, 1'b1, COORD_MAX, COORD_MAX);
    queue_tick(32'h0000_0035, 1'b1, 24'd5, -24'sd7);
    queue_tick(32'hFFFF_FFFF, 1'b0, '1, '1);
    wait_idle();

    // zero time constant acts as one; forward-only around origin 0
    write_reg(CFG_TIME_CONSTANT, '0);
    write_reg(CFG_FORWARD_ONLY, 24'd1);
    write_reg(CFG_ORIGIN_COL, '0);
    queue_tick(32'd100, 1'b1, '0, 24'd5);
    queue_tick(32'd101, 1'b1, '1, 24'd7);
    queue_tick(32'd200, 1'b1, COORD_MAX, -24'sd3);
    queue_tick(32'd200, 1'b1, COORD_MIN, COORD_MIN);
    wait_idle();

    // origin at the extremes, largest time constant
    write_reg(CFG_TIME_CONSTANT, 24'hFFFF);
    write_reg(CFG_ORIGIN_COL, COORD_MIN);
    queue_tick(32'd300, 1'b1, COORD_MIN, 24'd77);
    wait_idle();
    write_reg(CFG_ORIGIN_COL, COORD_MAX);
    queue_tick(32'd400, 1'b1, COORD_MAX, -24'sd77);
    queue_tick(32'd401, 1'b1, 24'(COORD_MAX - 1), 24'd9);
    queue_tick(32'd400, 1'b1, -24'sd9, COORD_MAX);
    queue_tick(32'd90000, 1'b1, 24'd4000, -24'sd4000);
    wait_idle();

    // Random phases: mostly valid ticks with dt spread over the table range,
    // some beyond it, some zero, some arbitrary; a few stopped ticks.
    gen_time = last_stamp;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       tau = 16'd1;
        1:       tau = 16'hFFFF;
        2:       tau = TAU_W'($urandom_range(2, 40));
        default: tau = ($urandom_range(0, 1) != 0) ? TAU_W'($urandom_range(1, 3000))
                                                   : TAU_W'($urandom_range(1, 65535));
      endcase
      case (ph)
        3:       org = COORD_MIN;
        4:       org = COORD_MAX;
        default: org = ($urandom_range(0, 1) != 0) ? CW'($urandom)
                                                   : CW'(int'($urandom_range(0, 8191)) - 4096);
      endcase
      write_reg(CFG_TIME_CONSTANT, CFG_DATA_W'(tau));
      write_reg(CFG_FORWARD_ONLY, CFG_DATA_W'((ph % 2 == 1) || (ph == 4)));
      write_reg(CFG_ORIGIN_COL, org);
      span = 16 * int'(tau);
      for (int k = 0; k < PHASE_TICKS; k++) begin
        if ($urandom_range(0, 99) < 8) begin
          queue_tick($urandom, 1'b0, CW'($urandom), CW'($urandom));
        end else begin
          sel = $urandom_range(0, 19);
          if (sel < 12) dt = $urandom_range(0, span - 1);
          else if (sel < 14) dt = 0;
          else if (sel < 16) dt = span + $urandom_range(0, span);
          else if (sel < 18) dt = $urandom;
          else dt = span - 1 + $urandom_range(0, 1);
          gen_time += dt;
          queue_tick(gen_time, 1'b1, pick_coord(int'(org)), pick_coord(0));
        end
      end
      wait_idle();
    end

    if (field_mismatches == 0 && expected_moves.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #6_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/taps_pkg.sv
rtl/core/taps_rom.sv
rtl/core/taps_mul.sv
rtl/core/taps_div.sv
rtl/core/time_adaptive_pointer_smoother_top.sv
rtl/core/taps_chk.sv
bench/tb_time_adaptive_pointer_smoother_top.sv
